### rtl/cbc_pkg.sv
// Shared types and constants for the cell balance charge controller.
package cbc_pkg;

  localparam int unsigned CellCount = 6;
  localparam int unsigned CodeW     = 15;
  localparam int unsigned CellW     = 16;

  typedef enum logic [1:0] {
    REG_MAX_CELL    = 2'd0,
    REG_MIN_CELL    = 2'd1,
    REG_ALLOW_DELTA = 2'd2,
    REG_CHARGED     = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_LOW        = 2'd0,
    CLS_OVER       = 2'd1,
    CLS_BALANCED   = 2'd2,
    CLS_UNBALANCED = 2'd3
  } pack_class_e;

  localparam logic [CodeW-1:0] MaxCellReset    = 15'd22545;
  localparam logic [CodeW-1:0] MinCellReset    = 15'd13108;
  localparam logic [CodeW-1:0] AllowDeltaReset = 15'd786;
  localparam logic [CodeW-1:0] ChargedReset    = 15'd20395;

  typedef struct packed {
    logic [CodeW-1:0] max_cell_code;
    logic [CodeW-1:0] min_cell_code;
    logic [CodeW-1:0] allowed_delta_code;
    logic [CodeW-1:0] charged_cell_code;
  } cfg_t;

  typedef struct packed {
    logic low;
    logic over;
  } lane_flags_t;

  typedef struct packed {
    logic                    docked;
    logic                    balance_running;
    logic signed [CellW-1:0] cell_0;
    logic signed [CellW-1:0] cell_1;
    logic signed [CellW-1:0] cell_2;
    logic signed [CellW-1:0] cell_3;
    logic signed [CellW-1:0] cell_4;
    logic signed [CellW-1:0] cell_5;
  } in_word_t;

  typedef struct packed {
    logic [2:0] next_mode;
    logic       charge_on;
    logic       balance_start;
    logic       balance_stop;
    logic [1:0] pack_class;
    logic       class_valid;
  } out_word_t;

endpackage

### rtl/cbc_lane.sv
// One cell lane: compare a cell code against the low and over-maximum limits.
module cbc_lane (
  input  logic signed [cbc_pkg::CellW-1:0] cell_i,
  input  cbc_pkg::cfg_t                    cfg_i,
  output cbc_pkg::lane_flags_t             flags_o
);

  logic signed [cbc_pkg::CellW-1:0] min_lim;
  logic signed [cbc_pkg::CellW-1:0] max_lim;

  assign min_lim = $signed({1'b0, cfg_i.min_cell_code});
  assign max_lim = $signed({1'b0, cfg_i.max_cell_code});

  assign flags_o.low  = (cell_i <= min_lim);
  assign flags_o.over = (cell_i >= max_lim);

endmodule

### rtl/cbc_merge.sv
// Merge stage: combine lane flags, find max, min and spread, and classify the pack.
module cbc_merge (
  input  logic signed [cbc_pkg::CellW-1:0] cells_i [cbc_pkg::CellCount],
  input  cbc_pkg::lane_flags_t             flags_i [cbc_pkg::CellCount],
  input  cbc_pkg::cfg_t                    cfg_i,
  output cbc_pkg::pack_class_e             class_o
);

  logic signed [cbc_pkg::CellW-1:0] hi;
  logic signed [cbc_pkg::CellW-1:0] lo;
  logic                             any_low;
  logic                             any_over;
  logic signed [cbc_pkg::CellW:0]   spread;
  logic                             balanced;

  always_comb begin
    hi       = cells_i[0];
    lo       = cells_i[0];
    any_low  = 1'b0;
    any_over = 1'b0;
    for (int i = 0; i < cbc_pkg::CellCount; i++) begin
      if (cells_i[i] > hi) hi = cells_i[i];
      if (cells_i[i] < lo) lo = cells_i[i];
      any_low  = any_low | flags_i[i].low;
      any_over = any_over | flags_i[i].over;
    end
  end

  assign spread   = {hi[cbc_pkg::CellW-1], hi} - {lo[cbc_pkg::CellW-1], lo};
  assign balanced = (spread < $signed({2'b00, cfg_i.allowed_delta_code}))
                 && (lo > $signed({1'b0, cfg_i.charged_cell_code}));

  always_comb begin
    if (any_low) begin
      class_o = cbc_pkg::CLS_LOW;
    end else if (any_over) begin
      class_o = cbc_pkg::CLS_OVER;
    end else if (balanced) begin
      class_o = cbc_pkg::CLS_BALANCED;
    end else begin
      class_o = cbc_pkg::CLS_UNBALANCED;
    end
  end

endmodule

### rtl/cell_balance_charge_controller.sv
// Top level of the cell balance charge controller: lanes, merge, mode machine, output skid.
//
// Each accepted word is one controller tick: six cell lanes compare their codes against
// the limits in parallel, a merge stage forms max, min, spread and the pack class, and
// the mode machine advances one state, all in the accept cycle. The result word is held
// in an output register with a one-word skid behind it, so a new word is taken every
// cycle while downstream keeps taking results.
module cell_balance_charge_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cbc_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cbc_pkg::out_word_t         out_word_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [cbc_pkg::CodeW-1:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    MODE_DOCK    = 3'd0,
    MODE_MEASURE = 3'd1,
    MODE_CHARGE  = 3'd2,
    MODE_BALANCE = 3'd3,
    MODE_STOP    = 3'd4
  } mode_e;

  cbc_pkg::cfg_t        cfg_q;
  mode_e                mode_q, mode_d;
  logic                 issued_q, issued_d;
  logic                 charge_q, charge_d;

  logic signed [cbc_pkg::CellW-1:0] cells [cbc_pkg::CellCount];
  cbc_pkg::lane_flags_t             flags [cbc_pkg::CellCount];
  cbc_pkg::pack_class_e             pack_class;

  cbc_pkg::out_word_t   res;
  cbc_pkg::out_word_t   main_q;
  cbc_pkg::out_word_t   skid_q;
  logic                 main_valid_q;
  logic                 skid_valid_q;
  logic                 in_fire;
  logic                 out_fire;

  assign cells[0] = in_word_i.cell_0;
  assign cells[1] = in_word_i.cell_1;
  assign cells[2] = in_word_i.cell_2;
  assign cells[3] = in_word_i.cell_3;
  assign cells[4] = in_word_i.cell_4;
  assign cells[5] = in_word_i.cell_5;

  for (genvar g = 0; g < cbc_pkg::CellCount; g++) begin : g_lane
    cbc_lane u_lane (
      .cell_i  (cells[g]),
      .cfg_i   (cfg_q),
      .flags_o (flags[g])
    );
  end

  cbc_merge u_merge (
    .cells_i (cells),
    .flags_i (flags),
    .cfg_i   (cfg_q),
    .class_o (pack_class)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_cell_code      <= cbc_pkg::MaxCellReset;
      cfg_q.min_cell_code      <= cbc_pkg::MinCellReset;
      cfg_q.allowed_delta_code <= cbc_pkg::AllowDeltaReset;
      cfg_q.charged_cell_code  <= cbc_pkg::ChargedReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbc_pkg::REG_MAX_CELL:    cfg_q.max_cell_code      <= cfg_data_i;
        cbc_pkg::REG_MIN_CELL:    cfg_q.min_cell_code      <= cfg_data_i;
        cbc_pkg::REG_ALLOW_DELTA: cfg_q.allowed_delta_code <= cfg_data_i;
        cbc_pkg::REG_CHARGED:     cfg_q.charged_cell_code  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // mode machine, next state and result word
  always_comb begin
    mode_d            = MODE_DOCK;
    issued_d          = issued_q;
    charge_d          = charge_q;
    res.balance_start = 1'b0;
    res.balance_stop  = 1'b0;
    res.pack_class    = cbc_pkg::CLS_LOW;
    res.class_valid   = 1'b0;
    case (mode_q)
      MODE_DOCK: begin
        mode_d = in_word_i.docked ? MODE_MEASURE : MODE_DOCK;
      end
      MODE_MEASURE: begin
        charge_d        = 1'b0;
        res.pack_class  = pack_class;
        res.class_valid = 1'b1;
        if (pack_class == cbc_pkg::CLS_OVER) begin
          mode_d = MODE_BALANCE;
        end else if (pack_class == cbc_pkg::CLS_UNBALANCED) begin
          mode_d = MODE_CHARGE;
        end else begin
          mode_d = MODE_MEASURE;
        end
        if (!in_word_i.docked) mode_d = MODE_DOCK;
      end
      MODE_CHARGE: begin
        if (in_word_i.docked) begin
          charge_d = 1'b1;
          mode_d   = MODE_BALANCE;
        end else begin
          mode_d = MODE_DOCK;
        end
      end
      MODE_BALANCE: begin
        res.balance_start = !issued_q;
        issued_d          = 1'b1;
        if (in_word_i.balance_running && in_word_i.docked) begin
          mode_d = MODE_BALANCE;
        end else begin
          issued_d = 1'b0;
          mode_d   = in_word_i.docked ? MODE_MEASURE : MODE_STOP;
        end
      end
      MODE_STOP: begin
        charge_d         = 1'b0;
        res.balance_stop = 1'b1;
        mode_d           = MODE_DOCK;
      end
      default: begin
        mode_d = MODE_DOCK;
      end
    endcase
    res.next_mode = mode_d;
    res.charge_on = charge_d;
  end

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = main_valid_q;
  assign out_word_o  = main_q;
  assign out_fire    = main_valid_q && out_ready_i;

  // advance state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_DOCK;
      issued_q <= 1'b0;
      charge_q <= 1'b0;
    end else if (in_fire) begin
      mode_q   <= mode_d;
      issued_q <= issued_d;
      charge_q <= charge_d;
    end
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!in_fire) begin
        main_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!main_valid_q) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (in_fire) begin
        main_q <= res;
      end
    end else if (in_fire) begin
      if (!main_valid_q) begin
        main_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid holds a word while the output register is empty");

  a_stop_to_dock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_q == MODE_STOP) |=> (mode_q == MODE_DOCK && !charge_q))
    else $error("stop tick did not return to dock with charging off");

  a_charge_from_charge_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(charge_q) |-> ($past(mode_q) == MODE_CHARGE && mode_q == MODE_BALANCE))
    else $error("charging turned on outside the charge enable step");

  a_pulses_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.balance_start && out_word_o.balance_stop))
    else $error("start and stop pulses in one word");

endmodule
